// ===== src/aa_triangle_pixel_coverage_macros.svh =====
// Assertion macros for the triangle pixel coverage block
`ifndef AA_TRIANGLE_PIXEL_COVERAGE_MACROS_SVH
`define AA_TRIANGLE_PIXEL_COVERAGE_MACROS_SVH

// same-cycle implication
`define AATPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aatpc: assertion failed");

// next-cycle implication
`define AATPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aatpc: assertion failed");

`endif

// ===== src/aatpc_pkg.sv =====
// Shared constants, types and functions of the triangle pixel coverage block
package aatpc_pkg;

   localparam int PIXEL_BITS    = 12;
   localparam int SUBPIXEL_BITS = 4;
   localparam int VERT_W        = 16;
   localparam int DIFF_W        = VERT_W + 1;
   localparam int RGB_W         = 24;
   localparam int ALPHA_W       = 8;
   localparam int ARGB_W        = ALPHA_W + RGB_W;
   localparam int NUM_EDGES     = 3;
   localparam int NUM_SAMPLES   = 4;
   localparam int HITS_W        = 3;
   localparam int SAMPLE_LO     = 1 << (SUBPIXEL_BITS - 2);
   localparam int SAMPLE_HI     = 3 * SAMPLE_LO;

   localparam int VP_W    = DIFF_W + VERT_W;
   localparam int C_W     = VP_W + 1;
   localparam int AREA_P_W = 2 * DIFF_W;
   localparam int AREA_W  = AREA_P_W + 1;
   localparam int PROD_W  = DIFF_W + PIXEL_BITS;
   localparam int T_W     = PROD_W + 1;
   localparam int EDGE_W  =
      ((T_W + SUBPIXEL_BITS > AREA_W) ? T_W + SUBPIXEL_BITS : AREA_W) + 1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_VERTEX_A_X,
      REG_VERTEX_A_Y,
      REG_VERTEX_B_X,
      REG_VERTEX_B_Y,
      REG_VERTEX_C_X,
      REG_VERTEX_C_Y,
      REG_FILL_RGB
   } reg_index_type;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [EDGE_W-1:0] edge_type;
   typedef logic signed [T_W-1:0]    tval_type;
   typedef tval_type [NUM_EDGES-1:0] tvec_type;

   typedef struct packed {
      diff_type [NUM_EDGES-1:0]                      dx;
      diff_type [NUM_EDGES-1:0]                      dy;
      edge_type [NUM_EDGES-1:0][NUM_SAMPLES-1:0]     k;
      logic                                          area_neg;
      logic                                          area_zero;
      logic [RGB_W-1:0]                              fill_rgb;
   } coef_type;

   // hits * 255 / 4
   function automatic logic [ALPHA_W-1:0] alpha_of(input logic [HITS_W-1:0] hits);
      logic [HITS_W+ALPHA_W-1:0] scaled;
      scaled = ((HITS_W+ALPHA_W)'(hits) << ALPHA_W) - (HITS_W+ALPHA_W)'(hits);
      return scaled[ALPHA_W+1:2];
   endfunction

endpackage

// ===== src/aatpc_if.sv =====
// Pixel request and covered-pixel response channel interfaces
interface aatpc_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [aatpc_pkg::PIXEL_BITS-1:0]   pixel_x;
   logic signed [aatpc_pkg::PIXEL_BITS-1:0]   pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface aatpc_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [aatpc_pkg::PIXEL_BITS-1:0]   out_x;
   logic signed [aatpc_pkg::PIXEL_BITS-1:0]   out_y;
   logic [aatpc_pkg::ARGB_W-1:0]              pixel_argb;

   modport source (output valid, output out_x, output out_y, output pixel_argb,
                   input ready);
   modport sink   (input valid, input out_x, input out_y, input pixel_argb,
                   output ready);
endinterface

// ===== src/aatpc_csr.sv =====
// Configuration registers and edge coefficient precompute
module aatpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [aatpc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [aatpc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [aatpc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output aatpc_pkg::coef_type                 coef
);

   logic [aatpc_pkg::VERT_W-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [aatpc_pkg::RGB_W-1:0]  rgb_ff;
   aatpc_pkg::reg_index_type     idx;
   logic                         wr;

   logic signed [aatpc_pkg::VERT_W-1:0]   org_x [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::VERT_W-1:0]   org_y [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::VERT_W-1:0]   end_x [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::VERT_W-1:0]   end_y [aatpc_pkg::NUM_EDGES];

   // stage 1
   logic signed [aatpc_pkg::DIFF_W-1:0]   dx_in [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::DIFF_W-1:0]   dy_in [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::DIFF_W-1:0]   dx_ff [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::DIFF_W-1:0]   dy_ff [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::VP_W-1:0]     yp_in [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::VP_W-1:0]     xp_in [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::VP_W-1:0]     yp_ff [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::VP_W-1:0]     xp_ff [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::DIFF_W-1:0]   acx, acy;
   logic signed [aatpc_pkg::AREA_P_W-1:0] area1_in, area2_in, area1_ff, area2_ff;

   // stage 2
   logic signed [aatpc_pkg::C_W-1:0]      c_in [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::C_W-1:0]      c_ff [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::AREA_W-1:0]   area_in, area_ff;
   logic signed [aatpc_pkg::EDGE_W-1:0]
      off_in [aatpc_pkg::NUM_EDGES][aatpc_pkg::NUM_SAMPLES];
   logic signed [aatpc_pkg::EDGE_W-1:0]
      off_ff [aatpc_pkg::NUM_EDGES][aatpc_pkg::NUM_SAMPLES];

   // stage 3
   logic signed [aatpc_pkg::EDGE_W-1:0]
      k_in [aatpc_pkg::NUM_EDGES][aatpc_pkg::NUM_SAMPLES];
   logic signed [aatpc_pkg::EDGE_W-1:0]
      k_ff [aatpc_pkg::NUM_EDGES][aatpc_pkg::NUM_SAMPLES];
   logic area_neg_ff, area_zero_ff;

   assign idx        = aatpc_pkg::reg_index_type'(csr_paddr[aatpc_pkg::CSR_ADDR_W-1:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff  <= '0;
         ay_ff  <= '0;
         bx_ff  <= '0;
         by_ff  <= '0;
         cx_ff  <= '0;
         cy_ff  <= '0;
         rgb_ff <= '0;
      end else if (wr) begin
         unique case (idx)
            aatpc_pkg::REG_VERTEX_A_X: ax_ff  <= csr_pwdata[aatpc_pkg::VERT_W-1:0];
            aatpc_pkg::REG_VERTEX_A_Y: ay_ff  <= csr_pwdata[aatpc_pkg::VERT_W-1:0];
            aatpc_pkg::REG_VERTEX_B_X: bx_ff  <= csr_pwdata[aatpc_pkg::VERT_W-1:0];
            aatpc_pkg::REG_VERTEX_B_Y: by_ff  <= csr_pwdata[aatpc_pkg::VERT_W-1:0];
            aatpc_pkg::REG_VERTEX_C_X: cx_ff  <= csr_pwdata[aatpc_pkg::VERT_W-1:0];
            aatpc_pkg::REG_VERTEX_C_Y: cy_ff  <= csr_pwdata[aatpc_pkg::VERT_W-1:0];
            aatpc_pkg::REG_FILL_RGB:   rgb_ff <= csr_pwdata[aatpc_pkg::RGB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         aatpc_pkg::REG_VERTEX_A_X: csr_prdata = aatpc_pkg::CSR_DATA_W'(ax_ff);
         aatpc_pkg::REG_VERTEX_A_Y: csr_prdata = aatpc_pkg::CSR_DATA_W'(ay_ff);
         aatpc_pkg::REG_VERTEX_B_X: csr_prdata = aatpc_pkg::CSR_DATA_W'(bx_ff);
         aatpc_pkg::REG_VERTEX_B_Y: csr_prdata = aatpc_pkg::CSR_DATA_W'(by_ff);
         aatpc_pkg::REG_VERTEX_C_X: csr_prdata = aatpc_pkg::CSR_DATA_W'(cx_ff);
         aatpc_pkg::REG_VERTEX_C_Y: csr_prdata = aatpc_pkg::CSR_DATA_W'(cy_ff);
         aatpc_pkg::REG_FILL_RGB:   csr_prdata = aatpc_pkg::CSR_DATA_W'(rgb_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // edges a->b, b->c, c->a
   assign org_x[0] = $signed(ax_ff);
   assign org_y[0] = $signed(ay_ff);
   assign end_x[0] = $signed(bx_ff);
   assign end_y[0] = $signed(by_ff);
   assign org_x[1] = $signed(bx_ff);
   assign org_y[1] = $signed(by_ff);
   assign end_x[1] = $signed(cx_ff);
   assign end_y[1] = $signed(cy_ff);
   assign org_x[2] = $signed(cx_ff);
   assign org_y[2] = $signed(cy_ff);
   assign end_x[2] = $signed(ax_ff);
   assign end_y[2] = $signed(ay_ff);

   always_comb begin
      for (int e = 0; e < aatpc_pkg::NUM_EDGES; e++) begin
         dx_in[e] = aatpc_pkg::DIFF_W'(end_x[e]) - aatpc_pkg::DIFF_W'(org_x[e]);
         dy_in[e] = aatpc_pkg::DIFF_W'(end_y[e]) - aatpc_pkg::DIFF_W'(org_y[e]);
         yp_in[e] = aatpc_pkg::VP_W'(dx_in[e]) * aatpc_pkg::VP_W'(org_y[e]);
         xp_in[e] = aatpc_pkg::VP_W'(dy_in[e]) * aatpc_pkg::VP_W'(org_x[e]);
      end
      acx      = aatpc_pkg::DIFF_W'(end_x[1]) - aatpc_pkg::DIFF_W'(org_x[0]);
      acy      = aatpc_pkg::DIFF_W'(end_y[1]) - aatpc_pkg::DIFF_W'(org_y[0]);
      area1_in = aatpc_pkg::AREA_P_W'(dx_in[0]) * aatpc_pkg::AREA_P_W'(acy);
      area2_in = aatpc_pkg::AREA_P_W'(dy_in[0]) * aatpc_pkg::AREA_P_W'(acx);
   end

   always_comb begin
      int ox;
      int oy;
      for (int e = 0; e < aatpc_pkg::NUM_EDGES; e++) begin
         c_in[e] = aatpc_pkg::C_W'(yp_ff[e]) - aatpc_pkg::C_W'(xp_ff[e]);
         for (int s = 0; s < aatpc_pkg::NUM_SAMPLES; s++) begin
            ox = ((s & 1) != 0) ? aatpc_pkg::SAMPLE_HI : aatpc_pkg::SAMPLE_LO;
            oy = ((s & 2) != 0) ? aatpc_pkg::SAMPLE_HI : aatpc_pkg::SAMPLE_LO;
            off_in[e][s] =
               aatpc_pkg::EDGE_W'(dx_ff[e]) * aatpc_pkg::EDGE_W'(oy) -
               aatpc_pkg::EDGE_W'(dy_ff[e]) * aatpc_pkg::EDGE_W'(ox);
            k_in[e][s] = off_ff[e][s] - aatpc_pkg::EDGE_W'(c_ff[e]);
         end
      end
      area_in = aatpc_pkg::AREA_W'(area1_ff) - aatpc_pkg::AREA_W'(area2_ff);
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      yp_ff    <= yp_in;
      xp_ff    <= xp_in;
      area1_ff <= area1_in;
      area2_ff <= area2_in;
      c_ff     <= c_in;
      area_ff  <= area_in;
      off_ff   <= off_in;
      k_ff     <= k_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_neg_ff  <= 1'b0;
         area_zero_ff <= 1'b1;
      end else begin
         area_neg_ff  <= area_ff[aatpc_pkg::AREA_W-1];
         area_zero_ff <= (area_ff == '0);
      end
   end

   always_comb begin
      for (int e = 0; e < aatpc_pkg::NUM_EDGES; e++) begin
         coef.dx[e] = dx_ff[e];
         coef.dy[e] = dy_ff[e];
         for (int s = 0; s < aatpc_pkg::NUM_SAMPLES; s++) begin
            coef.k[e][s] = k_ff[e][s];
         end
      end
      coef.area_neg  = area_neg_ff;
      coef.area_zero = area_zero_ff;
      coef.fill_rgb  = rgb_ff;
   end

endmodule

// ===== src/aatpc_cover.sv =====
// Sub-sample edge tests and hit count for one pixel
module aatpc_cover (
   input  aatpc_pkg::tvec_type           t,
   input  aatpc_pkg::coef_type           coef,
   output logic [aatpc_pkg::HITS_W-1:0]  hits
);

   logic [aatpc_pkg::NUM_SAMPLES-1:0] covered;

   always_comb begin
      logic signed [aatpc_pkg::EDGE_W-1:0] ev;
      logic                                ok;
      for (int s = 0; s < aatpc_pkg::NUM_SAMPLES; s++) begin
         covered[s] = 1'b1;
         for (int e = 0; e < aatpc_pkg::NUM_EDGES; e++) begin
            ev = (aatpc_pkg::EDGE_W'($signed(t[e])) <<< aatpc_pkg::SUBPIXEL_BITS) +
                 $signed(coef.k[e][s]);
            if (coef.area_neg) begin
               ok = ev[aatpc_pkg::EDGE_W-1] || (ev == '0);
            end else begin
               ok = !ev[aatpc_pkg::EDGE_W-1];
            end
            covered[s] = covered[s] && ok;
         end
      end
   end

   always_comb begin
      hits = '0;
      for (int s = 0; s < aatpc_pkg::NUM_SAMPLES; s++) begin
         hits = hits + aatpc_pkg::HITS_W'(covered[s]);
      end
   end

endmodule

// ===== src/aatpc_core.sv =====
// Pixel pipeline: input register, edge products, edge sums, output register
module aatpc_core (
   input  logic                 clock,
   input  logic                 reset,
   aatpc_req_if.sink            req,
   aatpc_rsp_if.source          rsp,
   input  aatpc_pkg::coef_type  coef
);

   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic out_free, s3_free, s2_free, s1_free, hit3;

   logic signed [aatpc_pkg::PIXEL_BITS-1:0] px1_ff, py1_ff, px2_ff, py2_ff;
   logic signed [aatpc_pkg::PIXEL_BITS-1:0] px3_ff, py3_ff, out_x_ff, out_y_ff;
   logic [aatpc_pkg::ARGB_W-1:0]            argb_ff;

   logic signed [aatpc_pkg::PROD_W-1:0] pyp_in [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::PROD_W-1:0] pxp_in [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::PROD_W-1:0] pyp_ff [aatpc_pkg::NUM_EDGES];
   logic signed [aatpc_pkg::PROD_W-1:0] pxp_ff [aatpc_pkg::NUM_EDGES];
   aatpc_pkg::tvec_type                 t_in, t3_ff;
   logic [aatpc_pkg::HITS_W-1:0]        hits3;

   aatpc_cover u_cover (
      .t    (t3_ff),
      .coef (coef),
      .hits (hits3)
   );

   assign hit3     = v3_ff && !coef.area_zero && (hits3 != '0);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s3_free  = !hit3 || out_free;
   assign s2_free  = !v2_ff || s3_free;
   assign s1_free  = !v1_ff || s2_free;
   assign req.ready = s1_free;

   always_comb begin
      for (int e = 0; e < aatpc_pkg::NUM_EDGES; e++) begin
         pyp_in[e] = aatpc_pkg::PROD_W'($signed(coef.dx[e])) *
                     aatpc_pkg::PROD_W'(py1_ff);
         pxp_in[e] = aatpc_pkg::PROD_W'($signed(coef.dy[e])) *
                     aatpc_pkg::PROD_W'(px1_ff);
         t_in[e]   = aatpc_pkg::T_W'(pyp_ff[e]) - aatpc_pkg::T_W'(pxp_ff[e]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) v1_ff <= req.valid;
         if (s2_free) v2_ff <= v1_ff;
         if (s3_free) v3_ff <= v2_ff;
         if (out_free) rsp_valid_ff <= hit3;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         px1_ff <= req.pixel_x;
         py1_ff <= req.pixel_y;
      end
      if (s2_free) begin
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         pyp_ff <= pyp_in;
         pxp_ff <= pxp_in;
      end
      if (s3_free) begin
         px3_ff <= px2_ff;
         py3_ff <= py2_ff;
         t3_ff  <= t_in;
      end
      if (out_free && hit3) begin
         out_x_ff <= px3_ff;
         out_y_ff <= py3_ff;
         argb_ff  <= {aatpc_pkg::alpha_of(hits3), coef.fill_rgb};
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_x      = out_x_ff;
   assign rsp.out_y      = out_y_ff;
   assign rsp.pixel_argb = argb_ff;

endmodule

// ===== src/aa_triangle_pixel_coverage.sv =====
// Top level of the anti-aliased triangle pixel coverage block
// Takes one pixel word per clock unless output back-pressure stalls it, and
// tests it against the configured triangle at four sub-samples (offsets 4
// and 12 sixteenths); covered pixels leave with alpha = hits*255/4 over the
// fill colour, uncovered pixels and all pixels of a zero-area triangle
// produce no word. Sustained rate is one pixel per cycle without stalls; a
// result word passes the pixel pipeline (input register, per-edge multipliers,
// edge sums, sample test into the output register). Vertex registers feed a
// three-stage coefficient precompute; the user must make writes only while
// the block holds no pixel in flight, which the block does not enforce.
module aa_triangle_pixel_coverage (
   input  logic                                clock,
   input  logic                                reset,
   aatpc_req_if.sink                           req,
   aatpc_rsp_if.source                         rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [aatpc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [aatpc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [aatpc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   aatpc_pkg::coef_type coef;

   aatpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   aatpc_core u_core (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .coef  (coef)
   );

endmodule

// ===== src/aatpc_checker.sv =====
// Port-level assertion checker for the triangle pixel coverage block
`include "aa_triangle_pixel_coverage_macros.svh"

module aatpc_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [aatpc_pkg::PIXEL_BITS-1:0]  out_x,
   input logic signed [aatpc_pkg::PIXEL_BITS-1:0]  out_y,
   input logic [aatpc_pkg::ARGB_W-1:0]             pixel_argb
);

   // a stalled word holds
   `AATPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_x) && $stable(out_y) && $stable(pixel_argb))

   // alpha is one of 63, 127, 191, 255
   `AATPC_ASSERT_NOW(a_alpha_code, clock, reset, rsp_valid, pixel_argb[29:24] == 6'h3F)

   // nothing leaves straight out of reset
   `AATPC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind aa_triangle_pixel_coverage aatpc_checker u_aatpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .out_x      (rsp.out_x),
   .out_y      (rsp.out_y),
   .pixel_argb (rsp.pixel_argb)
);
